// File: design/rrj_pkg.sv
// Package for the three-joint arm kinematics block: widths, CORDIC constants,
// configuration register indexes and shared types. No dependencies.
package rrj_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int FRAC_BITS    = 12;
  localparam int REG_BITS     = 15;
  localparam int OUT_BITS     = 20;
  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 34;  // CORDIC datapath width, Q30 plus headroom
  localparam int TRIG_BITS    = FRAC_BITS + 2;  // holds +/- 1.0 in Q.F
  localparam int IDX_BITS     = 2;

  localparam logic [IDX_BITS-1:0] REG_BASE_HEIGHT = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_UPPER_LINK  = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_FORE_LINK   = 2'd2;

  localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

  localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

  typedef logic [31:0] atan_tab_t [CORDIC_STEPS];

  // atan(2^-i) in units of 2^32 per turn
  localparam atan_tab_t ATAN_TURN = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic [REG_BITS-1:0] height;
    logic [REG_BITS-1:0] upper;
    logic [REG_BITS-1:0] fore;
  } arm_cfg_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] tip_x;
    logic signed [OUT_BITS-1:0] tip_y;
    logic signed [OUT_BITS-1:0] tip_z;
    logic signed [OUT_BITS-1:0] jac_x_shoulder;
    logic signed [OUT_BITS-1:0] jac_y_shoulder;
    logic signed [OUT_BITS-1:0] jac_z_shoulder;
    logic signed [OUT_BITS-1:0] jac_x_elbow;
    logic signed [OUT_BITS-1:0] jac_y_elbow;
    logic signed [OUT_BITS-1:0] jac_z_elbow;
  } arm_res_t;

  // Round half up from Q(FRAC_BITS+s) down by s bits.
  function automatic logic signed [47:0] rnd_shift(input logic signed [47:0] v,
                                                   input int s);
    logic signed [47:0] t;
    t = v + (48'sd1 <<< (s - 1));
    return t >>> s;
  endfunction

  function automatic logic signed [OUT_BITS-1:0] sat(input logic signed [47:0] v);
    logic signed [OUT_BITS-1:0] r;
    if (v > 48'(OUT_MAX)) r = OUT_MAX;
    else if (v < 48'(OUT_MIN)) r = OUT_MIN;
    else r = v[OUT_BITS-1:0];
    return r;
  endfunction

endpackage

// File: design/rrj_cordic.sv
// Pipelined rotation-mode CORDIC: one binary angle in, cosine and sine in
// Q.FRAC_BITS out, CORDIC_STEPS+2 register stages with stall. Depends on rrj_pkg.
module rrj_cordic (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [rrj_pkg::ANGLE_BITS-1:0]        angle,
  output logic                                  out_valid,
  output logic signed [rrj_pkg::TRIG_BITS-1:0]  cos_q,
  output logic signed [rrj_pkg::TRIG_BITS-1:0]  sin_q
);
  import rrj_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic signed [CW-1:0] xs [N+1];
  logic signed [CW-1:0] ys [N+1];
  logic signed [CW-1:0] zs [N+1];
  logic [1:0]           qs [N+1];
  logic [N:0]           vs;

  logic [31:0] full;
  assign full = 32'(angle) << (32 - ANGLE_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs <= {vs[N-1:0], in_valid};
    end
  end

  // Stage 0 loads the angle within its quadrant; each later stage is one
  // micro-rotation with a fixed shift.
  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= CORDIC_K;
      ys[0] <= '0;
      zs[0] <= CW'({2'b00, full[29:0]});
      qs[0] <= full[31:30];
      for (int i = 0; i < N; i++) begin
        qs[i+1] <= qs[i];
        if (!zs[i][CW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - signed'(CW'(ATAN_TURN[i]));
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + signed'(CW'(ATAN_TURN[i]));
        end
      end
    end
  end

  logic signed [CW-1:0] cr, sr;
  always_comb begin
    unique case (qs[N])
      2'd0: begin cr = xs[N];  sr = ys[N];  end
      2'd1: begin cr = -ys[N]; sr = xs[N];  end
      2'd2: begin cr = -xs[N]; sr = -ys[N]; end
      default: begin cr = ys[N]; sr = -xs[N]; end
    endcase
  end

  logic signed [47:0] cw, sw;
  assign cw = rnd_shift(48'(cr), 30 - FRAC_BITS);
  assign sw = rnd_shift(48'(sr), 30 - FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= cw[TRIG_BITS-1:0];
      sin_q <= sw[TRIG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vs[N];
    end
  end

endmodule

// File: design/rrj_kin.sv
// Kinematics back end: link products, sums, joint-1 rotation, then rounding and
// saturation, four register stages with stall. Depends on rrj_pkg.
module rrj_kin (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  rrj_pkg::arm_cfg_t                    cfg,
  input  logic signed [rrj_pkg::TRIG_BITS-1:0] c1,
  input  logic signed [rrj_pkg::TRIG_BITS-1:0] s1,
  input  logic signed [rrj_pkg::TRIG_BITS-1:0] c2,
  input  logic signed [rrj_pkg::TRIG_BITS-1:0] s2,
  input  logic signed [rrj_pkg::TRIG_BITS-1:0] c23,
  input  logic signed [rrj_pkg::TRIG_BITS-1:0] s23,
  output logic                                 out_valid,
  output rrj_pkg::arm_res_t                    res
);
  import rrj_pkg::*;

  // Stage 1: link length times trig terms.
  logic signed [31:0] p_l2c2, p_l2s2, p_l3c23, p_l3s23;
  logic signed [TRIG_BITS-1:0] c1_a, s1_a;
  logic [REG_BITS-1:0] h_a;
  logic v_a;

  always_ff @(posedge clk) begin
    if (en) begin
      p_l2c2  <= 32'(signed'({1'b0, cfg.upper})) * 32'(c2);
      p_l2s2  <= 32'(signed'({1'b0, cfg.upper})) * 32'(s2);
      p_l3c23 <= 32'(signed'({1'b0, cfg.fore})) * 32'(c23);
      p_l3s23 <= 32'(signed'({1'b0, cfg.fore})) * 32'(s23);
      c1_a <= c1;
      s1_a <= s1;
      h_a  <= cfg.height;
    end
  end

  // Stage 2: sums rounded to A, B, C, E; each stays within 18 bits.
  logic signed [19:0] a_b, b_b, cc_b, e_b;
  logic signed [TRIG_BITS-1:0] c1_b, s1_b;
  logic [REG_BITS-1:0] h_b;
  logic v_b;

  always_ff @(posedge clk) begin
    if (en) begin
      a_b  <= 20'(rnd_shift(48'(p_l2c2) + 48'(p_l3c23), FRAC_BITS));
      b_b  <= 20'(rnd_shift(48'(p_l2s2) + 48'(p_l3s23), FRAC_BITS));
      cc_b <= 20'(rnd_shift(48'(p_l3c23), FRAC_BITS));
      e_b  <= 20'(rnd_shift(48'(p_l3s23), FRAC_BITS));
      c1_b <= c1_a;
      s1_b <= s1_a;
      h_b  <= h_a;
    end
  end

  // Stage 3: rotation about the base axis.
  logic signed [31:0] xa, ya, xb, yb, xe, ye;
  logic signed [19:0] a_c, b_c, cc_c;
  logic [REG_BITS-1:0] h_c;
  logic v_c;

  always_ff @(posedge clk) begin
    if (en) begin
      xa   <= 32'(c1_b) * 32'(a_b);
      ya   <= 32'(s1_b) * 32'(a_b);
      xb   <= 32'(c1_b) * 32'(b_b);
      yb   <= 32'(s1_b) * 32'(b_b);
      xe   <= 32'(c1_b) * 32'(e_b);
      ye   <= 32'(s1_b) * 32'(e_b);
      a_c  <= a_b;
      b_c  <= b_b;
      cc_c <= cc_b;
      h_c  <= h_b;
    end
  end

  // Stage 4: rounding and saturation into the output register.
  always_ff @(posedge clk) begin
    if (en) begin
      res.tip_x          <= sat(rnd_shift(48'(xa), FRAC_BITS));
      res.tip_y          <= sat(rnd_shift(48'(ya), FRAC_BITS));
      res.tip_z          <= sat(48'(signed'({1'b0, h_c})) + 48'(b_c));
      res.jac_x_shoulder <= sat(-rnd_shift(48'(xb), FRAC_BITS));
      res.jac_y_shoulder <= sat(-rnd_shift(48'(yb), FRAC_BITS));
      res.jac_z_shoulder <= sat(48'(a_c));
      res.jac_x_elbow    <= sat(-rnd_shift(48'(xe), FRAC_BITS));
      res.jac_y_elbow    <= sat(-rnd_shift(48'(ye), FRAC_BITS));
      res.jac_z_elbow    <= sat(48'(cc_c));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_a <= in_valid;
      v_b <= v_a;
      v_c <= v_b;
      out_valid <= v_c;
    end
  end

endmodule

// File: design/rrr_arm_kinematics_jacobian.sv
// Channel  | Group            | Contents (lowest bit first)
// input    | s_axis_t*        | tdata: angle_base, angle_shoulder, angle_elbow
// output   | m_axis_t*        | tdata: tip xyz, jac base xyz, shoulder xyz, elbow xyz
// config   | cfg_we/idx/data  | base_height, upper_link_length, fore_link_length
// One item per cycle unless the output stalls; 32 CORDIC stages, 4 kinematics stages.
// The whole pipeline advances together; when the output holds a result that is
// not taken, every stage stalls, so nothing is lost or repeated.
// Synchronous reset clears valid bits and restores register defaults.
// Top level: three CORDIC pipelines and the kinematics stage. Depends on rrj_pkg.
module rrr_arm_kinematics_jacobian (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // angle_base, angle_shoulder, angle_elbow
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [239:0] m_axis_tdata,   // tip_x,y,z, jac_x,y,z_base, _shoulder, _elbow
  input  logic         cfg_we,
  input  logic [rrj_pkg::IDX_BITS-1:0] cfg_idx,
  input  logic [rrj_pkg::REG_BITS-1:0] cfg_data
);
  import rrj_pkg::*;

  arm_cfg_t cfg;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.height <= REG_BITS'(4096);
      cfg.upper  <= REG_BITS'(4096);
      cfg.fore   <= REG_BITS'(4096);
    end else if (cfg_we) begin
      priority case (cfg_idx)
        REG_BASE_HEIGHT: cfg.height <= cfg_data;
        REG_UPPER_LINK:  cfg.upper  <= cfg_data;
        REG_FORE_LINK:   cfg.fore   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic in_v;
  assign in_v = s_axis_tvalid && s_axis_tready;

  logic [ANGLE_BITS-1:0] t1, t2, t23;
  assign t1  = s_axis_tdata[ANGLE_BITS-1:0];
  assign t2  = s_axis_tdata[16 +: ANGLE_BITS];
  assign t23 = s_axis_tdata[16 +: ANGLE_BITS] + s_axis_tdata[32 +: ANGLE_BITS];

  logic v1, v2, v3;
  logic signed [TRIG_BITS-1:0] c1, s1, c2, s2, c23, s23;

  rrj_cordic u_cordic1 (.clk, .rst, .en, .in_valid(in_v), .angle(t1),
                        .out_valid(v1), .cos_q(c1), .sin_q(s1));
  rrj_cordic u_cordic2 (.clk, .rst, .en, .in_valid(in_v), .angle(t2),
                        .out_valid(v2), .cos_q(c2), .sin_q(s2));
  rrj_cordic u_cordic3 (.clk, .rst, .en, .in_valid(in_v), .angle(t23),
                        .out_valid(v3), .cos_q(c23), .sin_q(s23));

  arm_res_t res;
  rrj_kin u_kin (.clk, .rst, .en, .in_valid(v1), .cfg, .c1, .s1, .c2, .s2,
                 .c23, .s23, .out_valid(m_axis_tvalid), .res);

  // Base column is (-y, x, 0).
  assign m_axis_tdata = {res.jac_z_elbow, res.jac_y_elbow, res.jac_x_elbow,
                         res.jac_z_shoulder, res.jac_y_shoulder, res.jac_x_shoulder,
                         {OUT_BITS{1'b0}}, res.tip_x, sat(-48'(res.tip_y)),
                         res.tip_z, res.tip_y, res.tip_x};

  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    (v1 == v2) && (v2 == v3)) else $error("CORDIC lanes out of step");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[119:100] == '0) else $error("base z not zero");

endmodule
